// File: design/weno5_pkg.sv
// shared types and constants for the weno5 face reconstruction unit
package weno5_pkg;

    localparam int DATA_W        = 24;
    localparam int FRAC_BITS_DEF = 16;

    localparam int T_W    = 15;
    localparam int W_W    = 24;
    localparam int N_W    = DATA_W + 5;
    localparam int SUM_W  = W_W + 2;
    localparam int DEN_W  = SUM_W + 3;
    localparam int PROD_W = W_W + 1 + N_W;
    localparam int NUM_W  = PROD_W + 2;
    localparam int DIVD_W = NUM_W + 1;
    localparam int Q_W    = DATA_W + 1;
    localparam int DIFF_W = (DATA_W + 4 > 30) ? DATA_W + 4 : 30;
    localparam int MAG_W  = 29;

    localparam logic [63:0] EPS12_Q32 = 64'd51540;
    localparam logic [63:0] DIFF_CAP  = 64'd536870911;
    localparam logic [63:0] SCALE_CAP = 64'h4000_0000_0000_0000;

    typedef struct packed {
        logic signed [DATA_W-1:0] u_m2;
        logic signed [DATA_W-1:0] u_m1;
        logic signed [DATA_W-1:0] u_c0;
        logic signed [DATA_W-1:0] u_p1;
        logic signed [DATA_W-1:0] u_p2;
    } stencil_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] face_value;
        logic                     saturated;
    } face_t;

    typedef struct packed {
        logic valid;
        logic neg;
    } div_tag_t;

endpackage

// File: design/weno5_div.sv
// pipelined restoring divider, one quotient bit per stage
module weno5_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  weno5_pkg::div_tag_t           tag_in,
    input  logic [weno5_pkg::DIVD_W-1:0]  dividend,
    input  logic [weno5_pkg::DEN_W-1:0]   den,
    output weno5_pkg::div_tag_t           tag_out,
    output logic [weno5_pkg::Q_W-1:0]     quot
);

    localparam int QW = weno5_pkg::Q_W;
    localparam int DW = weno5_pkg::DIVD_W;
    localparam int EW = weno5_pkg::DEN_W;
    localparam int CW = DW + EW + QW;

    weno5_pkg::div_tag_t tag_reg [0:QW];
    logic [DW-1:0]       rem_reg [0:QW-1];
    logic [EW-1:0]       den_reg [0:QW-1];
    logic [QW-1:0]       q_reg   [0:QW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg[0] <= '0;
        end
        else if (en)
        begin
            tag_reg[0] <= tag_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= dividend;
            den_reg[0] <= den;
            q_reg[0]   <= '0;
        end
    end

    for (genvar j = 0; j < QW; j++)
    begin : g_step
        logic [CW-1:0] shifted;
        logic [CW-1:0] rem_ext;
        logic [CW-1:0] diff;
        logic          ge;

        assign shifted = CW'(den_reg[j]) << (QW - 1 - j);
        assign rem_ext = CW'(rem_reg[j]);
        assign diff    = rem_ext - shifted;
        assign ge      = (rem_ext >= shifted);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[j+1] <= '0;
            end
            else if (en)
            begin
                tag_reg[j+1] <= tag_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[j+1] <= {q_reg[j][QW-2:0], ge};
            end
        end

        // the last stage only needs the quotient bit
        if (j < QW - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j+1] <= ge ? diff[DW-1:0] : rem_reg[j];
                    den_reg[j+1] <= den_reg[j];
                end
            end
        end
    end

    assign tag_out = tag_reg[QW];
    assign quot    = q_reg[QW];

endmodule

// File: design/weno5_face_reconstruction_unit.sv
// fifth-order weno face reconstruction, fully pipelined datapath
// One stencil word enters per cycle and one face word leaves per cycle while face_stall
// does not hold the pipeline. It is 13 datapath stages, DATA_W+2 divider stages and one
// output register. The long tail is the normalizing division, built as a
// restoring divider that resolves one quotient bit per stage. face_stall holds the
// whole pipeline; stencil_stall is high exactly while a finished word is held.
module weno5_face_reconstruction_unit
#(
    parameter int FRAC_BITS = weno5_pkg::FRAC_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                stencil_valid,
    output logic                stencil_stall,
    input  weno5_pkg::stencil_t stencil,
    output logic                face_valid,
    input  logic                face_stall,
    output weno5_pkg::face_t    face
);

    localparam int DATA_W = weno5_pkg::DATA_W;
    localparam int N_W    = weno5_pkg::N_W;
    localparam int DIFF_W = weno5_pkg::DIFF_W;
    localparam int MAG_W  = weno5_pkg::MAG_W;
    localparam int T_W    = weno5_pkg::T_W;
    localparam int W_W    = weno5_pkg::W_W;
    localparam int SUM_W  = weno5_pkg::SUM_W;
    localparam int DEN_W  = weno5_pkg::DEN_W;
    localparam int PROD_W = weno5_pkg::PROD_W;
    localparam int NUM_W  = weno5_pkg::NUM_W;
    localparam int DIVD_W = weno5_pkg::DIVD_W;
    localparam int Q_W    = weno5_pkg::Q_W;
    localparam int E_SH   = 2 * FRAC_BITS - 32;
    localparam int SH_R   = (E_SH >= 0) ? E_SH : 0;
    localparam int SH_L   = (E_SH < 0) ? -E_SH : 0;
    localparam int NSTG   = 12;

    localparam logic [63:0]    SCALE_LIM = weno5_pkg::SCALE_CAP >> SH_L;
    localparam logic [Q_W-1:0] HI_Q      = {2'b00, {(DATA_W-1){1'b1}}};
    localparam logic [Q_W-1:0] LO_MAG    = HI_Q + 1'b1;

    typedef struct packed {
        logic signed [N_W-1:0] n1;
        logic signed [N_W-1:0] n2;
        logic signed [N_W-1:0] n3;
    } cand_t;

    function automatic logic [MAG_W-1:0] clamp_mag(input logic signed [DIFF_W-1:0] d);
        logic [DIFF_W-1:0] a;
        a = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
        return (a > DIFF_W'(weno5_pkg::DIFF_CAP)) ? MAG_W'(weno5_pkg::DIFF_CAP)
                                                   : a[MAG_W-1:0];
    endfunction

    function automatic logic [6:0] bit_len(input logic [63:0] x);
        logic [6:0] n;
        n = '0;
        for (int i = 0; i < 64; i++)
        begin
            if (x[i])
            begin
                n = 7'(i + 1);
            end
        end
        return n;
    endfunction

    function automatic logic [63:0] scale_s(input logic [63:0] sq_a, input logic [63:0] sq_b);
        logic [63:0] raw;
        logic [63:0] scaled;
        raw = (sq_a << 3) + (sq_a << 2) + sq_a + (sq_b << 1) + sq_b;
        if (E_SH >= 0)
        begin
            scaled = raw >> SH_R;
        end
        else if (raw > SCALE_LIM)
        begin
            scaled = weno5_pkg::SCALE_CAP;
        end
        else
        begin
            scaled = raw << SH_L;
        end
        return scaled + weno5_pkg::EPS12_Q32;
    endfunction

    function automatic logic [T_W-1:0] to_t(input logic [63:0] s, input logic [6:0] sh);
        logic [63:0] v;
        v = s >> sh;
        return (v[T_W-1:0] == '0) ? T_W'(1) : v[T_W-1:0];
    endfunction

    logic en;
    logic v_reg [0:NSTG];
    cand_t cand_reg [0:10];

    // stage 1: candidates and difference magnitudes
    cand_t            cand_next;
    logic [MAG_W-1:0] d1_next [0:2];
    logic [MAG_W-1:0] d2_next [0:2];
    logic [MAG_W-1:0] d1_reg  [0:2];
    logic [MAG_W-1:0] d2_reg  [0:2];

    always_comb
    begin
        logic signed [N_W-1:0]    a;
        logic signed [N_W-1:0]    b;
        logic signed [N_W-1:0]    c;
        logic signed [N_W-1:0]    d;
        logic signed [N_W-1:0]    e;
        logic signed [DIFF_W-1:0] x [0:4];
        a = N_W'(stencil.u_m2);
        b = N_W'(stencil.u_m1);
        c = N_W'(stencil.u_c0);
        d = N_W'(stencil.u_p1);
        e = N_W'(stencil.u_p2);
        cand_next.n1 = (a <<< 1) - ((b <<< 3) - b) + ((c <<< 3) + (c <<< 1) + c);
        cand_next.n2 = -b + ((c <<< 2) + c) + (d <<< 1);
        cand_next.n3 = (c <<< 1) + ((d <<< 2) + d) - e;
        x[0] = DIFF_W'(stencil.u_m2);
        x[1] = DIFF_W'(stencil.u_m1);
        x[2] = DIFF_W'(stencil.u_c0);
        x[3] = DIFF_W'(stencil.u_p1);
        x[4] = DIFF_W'(stencil.u_p2);
        for (int k = 0; k < 3; k++)
        begin
            d1_next[k] = clamp_mag(x[k] - (x[k+1] <<< 1) + x[k+2]);
            d2_next[k] = clamp_mag((x[k] <<< 1) + x[k] - (x[k+1] <<< 2) + x[k+2]);
        end
    end

    // stage 2: squares
    logic [63:0] sq1_reg [0:2];
    logic [63:0] sq2_reg [0:2];
    // stage 3: smoothness indicators (times 12, q.32)
    logic [63:0] s_reg   [0:2];
    // stage 4: common magnitude
    logic [63:0] s4_reg  [0:2];
    logic [63:0] sor_reg;
    // stage 5: first normalizing shift
    logic [63:0] s5_reg  [0:2];
    logic [6:0]  sh1_reg;
    logic [6:0]  len1;
    // stage 6: short indicators
    logic [T_W-1:0] t_reg [0:2];
    // stage 7: pair products
    logic [2*T_W-1:0] p23_reg;
    logic [2*T_W-1:0] p13_reg;
    logic [2*T_W-1:0] p12_reg;
    // stage 8: squared pairs
    logic [63:0] qq1_reg;
    logic [63:0] qq2_reg;
    logic [63:0] qq3_reg;
    // stage 9: raw weights
    logic [63:0] w9_reg [0:2];
    logic [63:0] wor_reg;
    // stage 10: second normalizing shift
    logic [63:0] w10_reg [0:2];
    logic [6:0]  sh2_reg;
    logic [6:0]  len2;
    // stage 11: short weights and sum
    logic [W_W-1:0]   w_reg [0:2];
    logic [SUM_W-1:0] sum_reg;
    // stage 12: weighted candidates
    logic signed [PROD_W-1:0] pr_reg [0:2];
    logic [SUM_W-1:0]         sum12_reg;
    // stage 13: numerator and divisor
    logic signed [NUM_W-1:0] num_reg;
    logic [SUM_W-1:0]        sum13_reg;

    logic [NUM_W-1:0]    num_mag;
    logic [DIVD_W-1:0]   dividend_next;
    logic [DEN_W-1:0]    den_next;
    weno5_pkg::div_tag_t tag_next;
    weno5_pkg::div_tag_t tag_out;
    logic [Q_W-1:0]      quot;

    weno5_pkg::face_t face_next;
    logic             face_valid_reg;
    weno5_pkg::face_t face_reg;

    assign en            = !(face_valid_reg && face_stall);
    assign stencil_stall = face_valid_reg && face_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= NSTG; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= stencil_valid;
            for (int k = 1; k <= NSTG; k++)
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    assign len1 = bit_len(sor_reg);
    assign len2 = bit_len(wor_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cand_reg[0] <= cand_next;
            for (int k = 1; k <= 10; k++)
            begin
                cand_reg[k] <= cand_reg[k-1];
            end
            for (int k = 0; k < 3; k++)
            begin
                d1_reg[k]  <= d1_next[k];
                d2_reg[k]  <= d2_next[k];
                sq1_reg[k] <= 64'(d1_reg[k]) * 64'(d1_reg[k]);
                sq2_reg[k] <= 64'(d2_reg[k]) * 64'(d2_reg[k]);
                s_reg[k]   <= scale_s(sq1_reg[k], sq2_reg[k]);
                s4_reg[k]  <= s_reg[k];
                s5_reg[k]  <= s4_reg[k];
                t_reg[k]   <= to_t(s5_reg[k], sh1_reg);
                w10_reg[k] <= w9_reg[k];
                w_reg[k]   <= W_W'(w10_reg[k] >> sh2_reg);
            end
            pr_reg[0] <= PROD_W'($signed({1'b0, w_reg[0]})) * PROD_W'(cand_reg[10].n1);
            pr_reg[1] <= PROD_W'($signed({1'b0, w_reg[1]})) * PROD_W'(cand_reg[10].n2);
            pr_reg[2] <= PROD_W'($signed({1'b0, w_reg[2]})) * PROD_W'(cand_reg[10].n3);
            sor_reg <= s_reg[0] | s_reg[1] | s_reg[2];
            sh1_reg <= (len1 > 7'(T_W)) ? (len1 - 7'(T_W)) : 7'd0;
            p23_reg <= t_reg[1] * t_reg[2];
            p13_reg <= t_reg[0] * t_reg[2];
            p12_reg <= t_reg[0] * t_reg[1];
            qq1_reg <= 64'(p23_reg) * 64'(p23_reg);
            qq2_reg <= 64'(p13_reg) * 64'(p13_reg);
            qq3_reg <= 64'(p12_reg) * 64'(p12_reg);
            w9_reg[0] <= qq1_reg;
            w9_reg[1] <= (qq2_reg << 2) + (qq2_reg << 1);
            w9_reg[2] <= (qq3_reg << 1) + qq3_reg;
            wor_reg <= qq1_reg | ((qq2_reg << 2) + (qq2_reg << 1))
                     | ((qq3_reg << 1) + qq3_reg);
            sh2_reg <= (len2 > 7'(W_W)) ? (len2 - 7'(W_W)) : 7'd0;
            sum_reg <= SUM_W'(W_W'(w10_reg[0] >> sh2_reg)) + SUM_W'(W_W'(w10_reg[1] >> sh2_reg))
                     + SUM_W'(W_W'(w10_reg[2] >> sh2_reg));
            sum12_reg <= sum_reg;
            num_reg   <= NUM_W'(pr_reg[0]) + NUM_W'(pr_reg[1]) + NUM_W'(pr_reg[2]);
            sum13_reg <= sum12_reg;
        end
    end

    // rounding to nearest, ties away from zero, by adding half the divisor
    assign num_mag       = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);
    assign dividend_next = DIVD_W'(num_mag) + (DIVD_W'(sum13_reg) << 1) + DIVD_W'(sum13_reg);
    assign den_next      = (DEN_W'(sum13_reg) << 2) + (DEN_W'(sum13_reg) << 1);
    assign tag_next.valid = v_reg[NSTG];
    assign tag_next.neg   = num_reg[NUM_W-1];

    weno5_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .tag_in   (tag_next),
        .dividend (dividend_next),
        .den      (den_next),
        .tag_out  (tag_out),
        .quot     (quot)
    );

    always_comb
    begin
        logic [Q_W-1:0] neg_q;
        neg_q = Q_W'(0) - quot;
        face_next.saturated  = 1'b0;
        face_next.face_value = quot[DATA_W-1:0];
        if (tag_out.neg)
        begin
            if (quot > LO_MAG)
            begin
                face_next.saturated  = 1'b1;
                face_next.face_value = {1'b1, {(DATA_W-1){1'b0}}};
            end
            else
            begin
                face_next.face_value = neg_q[DATA_W-1:0];
            end
        end
        else if (quot > HI_Q)
        begin
            face_next.saturated  = 1'b1;
            face_next.face_value = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            face_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            face_valid_reg <= tag_out.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            face_reg <= face_next;
        end
    end

    assign face_valid = face_valid_reg;
    assign face       = face_reg;

endmodule

// File: design/weno5_checker.sv
// port-level checks for the weno5 face reconstruction unit
module weno5_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                stencil_valid,
    input logic                stencil_stall,
    input weno5_pkg::stencil_t stencil,
    input logic                face_valid,
    input logic                face_stall,
    input weno5_pkg::face_t    face
);

    localparam int DATA_W = weno5_pkg::DATA_W;

    // a held word stays valid
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        face_valid && face_stall |=> face_valid)
        else $error("face word dropped while stalled");

    // a held word keeps its payload
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        face_valid && face_stall |=> $stable(face))
        else $error("face word changed while stalled");

    // a stalled stencil word is offered again unchanged
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        stencil_valid && stencil_stall |=> stencil_valid && $stable(stencil))
        else $error("stencil word changed while stalled");

    // input only backs up behind a held output word
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        stencil_stall |-> face_valid && face_stall)
        else $error("stencil stalled without output backpressure");

    // a clipped result sits on a rail
    a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
        face_valid && face.saturated |->
            face.face_value == {1'b0, {(DATA_W-1){1'b1}}} ||
            face.face_value == {1'b1, {(DATA_W-1){1'b0}}})
        else $error("saturated word not at a range limit");

endmodule

bind weno5_face_reconstruction_unit weno5_checker u_weno5_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .stencil_valid (stencil_valid),
    .stencil_stall (stencil_stall),
    .stencil       (stencil),
    .face_valid    (face_valid),
    .face_stall    (face_stall),
    .face          (face)
);
